FILE: rtl/bst_pkg.sv
// Shared types and codes for the binary search tree key store.
`timescale 1ns / 1ps
package bst_pkg;
  localparam logic [1:0] ACT_INSERT   = 2'd0;
  localparam logic [1:0] ACT_SEARCH   = 2'd1;
  localparam logic [1:0] ACT_TRAVERSE = 2'd2;
  localparam logic [1:0] ACT_UNDEF    = 2'd3;

  localparam logic [2:0] ST_INSERTED  = 3'd0;
  localparam logic [2:0] ST_DUPLICATE = 3'd1;
  localparam logic [2:0] ST_FULL      = 3'd2;
  localparam logic [2:0] ST_HIT       = 3'd3;
  localparam logic [2:0] ST_MISS      = 3'd4;
  localparam logic [2:0] ST_ELEMENT   = 3'd5;
  localparam logic [2:0] ST_EMPTY     = 3'd6;

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_READ  = 8'b0000_0010,
    S_CMP   = 8'b0000_0100,
    S_LINK  = 8'b0000_1000,
    S_PUSH  = 8'b0001_0000,
    S_LEFT  = 8'b0010_0000,
    S_POP   = 8'b0100_0000,
    S_OUT   = 8'b1000_0000
  } state_t;
endpackage

FILE: rtl/bst_ram.sv
// Generic single-port-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module bst_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd_data <= mem[rd_addr];
  end
endmodule

FILE: rtl/bst_key_store.sv
// Binary search tree key store over a fixed node pool held in RAM.
// Each node visited is read and then compared; a miss ends at a null link, and an insert
// rewrites the parent link, if any, and then writes the new leaf; traverse walks the stored nodes in order.
// One item is worked at a time; the next transfer is taken once its last result has left.
// Reset (synchronous, rst_n low) empties the tree: root null, node count zero.
// Node RAM contents are not cleared; only allocated nodes are ever reached.
`timescale 1ns / 1ps
module bst_key_store #(
  parameter int NODE_CAPACITY = 64,
  parameter int KEY_WIDTH     = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_action,
  input  logic [15:0] in_key,
  input  logic [15:0] in_item,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_status,
  output logic [15:0] out_out_key,
  output logic [15:0] out_out_item,
  output logic        out_last
);
  import bst_pkg::*;

  localparam int AW = $clog2(NODE_CAPACITY);
  localparam int LW = AW + 1;
  localparam int NW = KEY_WIDTH + 16 + 2 * LW;
  localparam logic [LW-1:0] NULL_LINK = LW'(NODE_CAPACITY);

  state_t          state_r;
  logic [1:0]      act_r;
  logic [KEY_WIDTH-1:0] key_r;
  logic [15:0]     item_r;
  logic [LW-1:0]   cur_r, parent_r, root_r, count_r;
  logic            left_r;
  logic [LW-1:0]   sp_r, cnt_r;
  logic [NW-1:0]   prec_r;

  // node record: key, item, left, right
  logic            nwr_en;
  logic [AW-1:0]   nwr_addr, nrd_addr;
  logic [NW-1:0]   nwr_data, nrd_data;
  logic            swr_en;
  logic [AW-1:0]   swr_addr, srd_addr;
  logic [AW-1:0]   srd_data;

  bst_ram #(.WIDTH(NW), .DEPTH(NODE_CAPACITY)) u_node (
    .clk, .wr_en(nwr_en), .wr_addr(nwr_addr), .wr_data(nwr_data),
    .rd_addr(nrd_addr), .rd_data(nrd_data));
  bst_ram #(.WIDTH(AW), .DEPTH(NODE_CAPACITY)) u_stack (
    .clk, .wr_en(swr_en), .wr_addr(swr_addr), .wr_data(cur_r[AW-1:0]),
    .rd_addr(srd_addr), .rd_data(srd_data));

  logic [KEY_WIDTH-1:0] n_key;
  logic [15:0]     n_item;
  logic [LW-1:0]   n_left, n_right;
  assign {n_key, n_item, n_left, n_right} = nrd_data;

  // parent record kept from the last compare of an insert walk
  logic [KEY_WIDTH-1:0] p_key;
  logic [15:0]     p_item;
  logic [LW-1:0]   p_left, p_right;
  assign {p_key, p_item, p_left, p_right} = prec_r;

  logic [LW-1:0] n_left_ok, n_right_ok;
  assign n_left_ok  = (n_left  < NULL_LINK) ? n_left  : NULL_LINK;
  assign n_right_ok = (n_right < NULL_LINK) ? n_right : NULL_LINK;

  logic ovalid_r;
  logic [2:0] ost_r;
  logic [15:0] okey_r, oitem_r;
  logic olast_r;
  logic [15:0] key_ext;
  assign key_ext = 16'(key_r);

  assign in_stall     = (state_r != S_IDLE) || ovalid_r;
  assign out_valid    = ovalid_r;
  assign out_status   = ost_r;
  assign out_out_key  = okey_r;
  assign out_out_item = oitem_r;
  assign out_last     = olast_r;

  logic cur_valid;
  assign cur_valid = cur_r < NULL_LINK;

  logic push_ok;
  assign push_ok = cur_valid && (sp_r < NULL_LINK);

  logic out_free, out_load, elem_last;
  logic [2:0]  ld_status;
  logic [15:0] ld_key, ld_item;
  logic        ld_last;
  assign out_free = !ovalid_r || !out_stall;
  // the walk ends after this element when nothing is to its right and the stack is empty, or at node capacity
  assign elem_last = (n_right_ok == NULL_LINK && sp_r == '0) ||
                     (cnt_r + LW'(1) >= NULL_LINK);

  // Result load: one source per state.
  always_comb begin
    out_load  = 1'b0;
    ld_status = ST_INSERTED;
    ld_key    = key_ext;
    ld_item   = '0;
    ld_last   = 1'b1;
    case (state_r)
      S_READ: begin
        if (!cur_valid) begin
          if (act_r == ACT_SEARCH) begin
            out_load  = 1'b1;
            ld_status = ST_MISS;
          end else if (count_r >= NULL_LINK) begin
            out_load  = 1'b1;
            ld_status = ST_FULL;
          end
        end
      end
      S_CMP: begin
        if (n_key == key_r) begin
          out_load  = 1'b1;
          ld_status = (act_r == ACT_INSERT) ? ST_DUPLICATE : ST_HIT;
          ld_item   = (act_r == ACT_INSERT) ? 16'd0 : n_item;
        end
      end
      S_LINK: out_load = 1'b1;
      S_PUSH: begin
        if (!push_ok && sp_r == '0) begin
          out_load  = 1'b1;
          ld_status = ST_EMPTY;
        end
      end
      S_OUT: begin
        if (out_free) begin
          out_load  = 1'b1;
          ld_status = ST_ELEMENT;
          ld_key    = 16'(n_key);
          ld_item   = n_item;
          ld_last   = elem_last;
        end
      end
      default: ;
    endcase
  end

  // Memory ports: rewrite the parent link, then write the new leaf; push the stack and read popped nodes.
  always_comb begin
    nwr_en   = 1'b0;
    nwr_addr = count_r[AW-1:0];
    nwr_data = {key_r, item_r, NULL_LINK, NULL_LINK};
    nrd_addr = cur_r[AW-1:0];
    swr_en   = 1'b0;
    swr_addr = sp_r[AW-1:0];
    srd_addr = AW'(sp_r - LW'(1));
    case (state_r)
      S_READ: begin
        if (!cur_valid && act_r == ACT_INSERT && count_r < NULL_LINK &&
            parent_r < NULL_LINK) begin
          nwr_en   = 1'b1;
          nwr_addr = parent_r[AW-1:0];
          nwr_data = left_r ? {p_key, p_item, count_r, p_right}
                            : {p_key, p_item, p_left, count_r};
        end
      end
      S_LINK: nwr_en = 1'b1;
      S_PUSH: swr_en = push_ok;
      S_POP:  nrd_addr = srd_data;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      root_r   <= NULL_LINK;
      count_r  <= '0;
      ovalid_r <= 1'b0;
    end else begin
      ovalid_r <= out_load || (ovalid_r && out_stall);
      if (out_load) begin
        ost_r   <= ld_status;
        okey_r  <= ld_key;
        oitem_r <= ld_item;
        olast_r <= ld_last;
      end
      case (state_r)
        S_IDLE: begin
          // undefined action: take the transfer and drop it
          if (in_valid && !in_stall && in_action != ACT_UNDEF) begin
            act_r    <= in_action;
            key_r    <= KEY_WIDTH'(in_key);
            item_r   <= in_item;
            cur_r    <= root_r;
            parent_r <= NULL_LINK;
            sp_r     <= '0;
            cnt_r    <= '0;
            state_r  <= (in_action == ACT_TRAVERSE) ? S_PUSH : S_READ;
          end
        end
        S_READ: begin
          if (cur_valid) state_r <= S_CMP;
          else if (act_r == ACT_SEARCH || count_r >= NULL_LINK) state_r <= S_IDLE;
          else begin
            if (parent_r >= NULL_LINK) root_r <= count_r;
            state_r <= S_LINK;
          end
        end
        S_CMP: begin
          if (n_key == key_r) state_r <= S_IDLE;
          else begin
            parent_r <= cur_r;
            prec_r   <= nrd_data;
            left_r   <= key_r < n_key;
            cur_r    <= (key_r < n_key) ? n_left_ok : n_right_ok;
            state_r  <= S_READ;
          end
        end
        S_LINK: begin
          count_r <= count_r + LW'(1);
          state_r <= S_IDLE;
        end
        S_PUSH: begin
          if (push_ok) begin
            sp_r    <= sp_r + LW'(1);
            state_r <= S_LEFT;
          end else if (sp_r == '0) begin
            state_r <= S_IDLE;
          end else begin
            sp_r    <= sp_r - LW'(1);
            state_r <= S_POP;
          end
        end
        S_LEFT: begin
          // record of pushed node arrives; go to its left child
          cur_r   <= n_left_ok;
          state_r <= S_PUSH;
        end
        S_POP: begin
          cur_r   <= LW'(srd_data);
          state_r <= S_OUT;
        end
        S_OUT: begin
          // hold the popped record until the output is free
          if (out_free) begin
            cnt_r   <= cnt_r + LW'(1);
            cur_r   <= n_right_ok;
            state_r <= elem_last ? S_IDLE : S_PUSH;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end
endmodule
